// ===== rtl/pfcba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcba_pkg
// Shared constants, types and codes of the per-frame chunked bump allocator.
// ----------------------------------------------------------------------------
package pfcba_pkg;

	// sizing
	localparam int FRAME_SLOTS = 2;
	localparam int MAX_CHUNKS  = 8;
	localparam int SIZE_BITS   = 25;

	localparam int SLOT_W      = 1;
	localparam int CHUNK_W     = 3;
	localparam int CNT_W       = CHUNK_W + 1;
	localparam int ENT_W       = SLOT_W + CHUNK_W;
	localparam int NUM_ENTRIES = FRAME_SLOTS * MAX_CHUNKS;

	// field widths
	localparam int FRAME_W = 32;
	localparam int REQ_W   = 24;
	localparam int ALIGN_W = 4;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_BITS;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DFLT_CHUNK = 1'd1;

	localparam logic [ALIGN_W-1:0]   ALIGN_RST = 4'd4;
	localparam logic [SIZE_BITS-1:0] DFLT_RST  = 25'd65536;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request fields
		logic prep;     // frame recycle and size rounding
		logic advance;  // step cursor past a full chunk
		logic hit;      // bump offset of cursor chunk
		logic append;   // append a new chunk
		logic full;     // report failure
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_chunk;  // cursor below chunk count
		logic fits;       // request fits in cursor chunk
		logic slot_full;  // slot holds MAX_CHUNKS chunks
	} sts_t;

endpackage : pfcba_pkg
`default_nettype wire

// ===== rtl/pfcba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcba_ctrl
// Sequencer: accepts a request, runs frame recycle, then walks the slot's
// chunks one per cycle until it can commit a hit, an append or a failure.
// ----------------------------------------------------------------------------
module pfcba_ctrl
	import pfcba_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.has_chunk) begin
					if (sts.slot_full) begin
						cmd.full = 1'b1;
					end else begin
						cmd.append = 1'b1;
					end
					state_d = ST_IDLE;
				end else if (sts.fits) begin
					cmd.hit = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// checks
	a_start_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_PREP)
		else $error("accepted request did not enter preparation");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.advance, cmd.hit, cmd.append, cmd.full}))
		else $error("more than one scan action in a cycle");

	a_commit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hit || cmd.append || cmd.full) |=> state_q == ST_IDLE)
		else $error("commit did not return to idle");

endmodule : pfcba_ctrl
`default_nettype wire

// ===== rtl/pfcba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcba_dp
// Datapath: configuration registers, per-slot cursor and count, chunk
// offset and capacity stores, fit test and registered result.
// ----------------------------------------------------------------------------
module pfcba_dp
	import pfcba_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration writes
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	// request fields
	input  wire  [FRAME_W-1:0]    frame_number,
	input  wire  [SLOT_W-1:0]     slot_index,
	input  wire  [REQ_W-1:0]      request_bytes,
	// control
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	// result
	output logic                  done,
	output logic [CHUNK_W-1:0]    chunk_index,
	output logic [SIZE_BITS-1:0]  byte_offset,
	output logic                  new_chunk,
	output logic [SIZE_BITS-1:0]  new_chunk_bytes,
	output logic                  full_res
);

	// configuration
	logic [ALIGN_W-1:0]   align_log2_q;
	logic [SIZE_BITS-1:0] dflt_chunk_q;

	// request being served
	logic [FRAME_W-1:0]   frame_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [REQ_W-1:0]     req_q;
	logic [SIZE_BITS-1:0] aligned_q;

	// allocator state
	logic [FRAME_W-1:0]   last_frame_q;
	logic                 last_valid_q;
	logic [CNT_W-1:0]     cursor_q [FRAME_SLOTS];
	logic [CNT_W-1:0]     count_q  [FRAME_SLOTS];
	logic [NUM_ENTRIES-1:0] live_q;  // offset written since slot recycle
	logic [SIZE_BITS-1:0] offset_q [NUM_ENTRIES];
	logic [SIZE_BITS-1:0] cap_q    [NUM_ENTRIES];

	logic                 done_q;
	logic [CHUNK_W-1:0]   chunk_index_q;
	logic [SIZE_BITS-1:0] byte_offset_q;
	logic                 new_chunk_q;
	logic [SIZE_BITS-1:0] new_bytes_q;
	logic                 full_res_q;

	logic                 new_frame;
	logic [SIZE_BITS-1:0] align_m1;
	logic [SIZE_BITS-1:0] aligned_d;
	logic [NUM_ENTRIES-1:0] slot_mask;
	logic [CNT_W-1:0]     cur;
	logic [CNT_W-1:0]     cnt;
	logic [ENT_W-1:0]     ent;
	logic [ENT_W-1:0]     ent_new;
	logic [SIZE_BITS-1:0] off_eff;
	logic [SIZE_BITS:0]   off_sum;
	logic [SIZE_BITS-1:0] new_cap;

	// rounding and recycle decision
	always_comb begin
		new_frame = !last_valid_q || (frame_q != last_frame_q);
		align_m1  = (SIZE_BITS'(1) << align_log2_q) - SIZE_BITS'(1);
		aligned_d = (SIZE_BITS'(req_q) + align_m1) & ~align_m1;
		slot_mask = NUM_ENTRIES'({MAX_CHUNKS{1'b1}}) << {slot_q, {CHUNK_W{1'b0}}};
	end

	// cursor chunk lookup and fit test
	always_comb begin
		cur           = cursor_q[slot_q];
		cnt           = count_q[slot_q];
		ent           = {slot_q, cur[CHUNK_W-1:0]};
		ent_new       = {slot_q, cnt[CHUNK_W-1:0]};
		off_eff       = live_q[ent] ? offset_q[ent] : '0;
		off_sum       = {1'b0, off_eff} + {1'b0, aligned_q};
		new_cap       = (aligned_q > dflt_chunk_q) ? aligned_q : dflt_chunk_q;
		sts.has_chunk = (cur < cnt);
		sts.fits      = (off_sum <= {1'b0, cap_q[ent]});
		sts.slot_full = (cnt >= CNT_W'(MAX_CHUNKS));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_log2_q <= ALIGN_RST;
			dflt_chunk_q <= DFLT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALIGN_LOG2: align_log2_q <= cfg_data[ALIGN_W-1:0];
				CFG_DFLT_CHUNK: dflt_chunk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state: frame tracking, cursors, counts, live bits, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_q <= '0;
			last_valid_q <= 1'b0;
			for (int s = 0; s < FRAME_SLOTS; s++) begin
				cursor_q[s] <= '0;
				count_q[s]  <= '0;
			end
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.hit || cmd.append || cmd.full;
			if (cmd.prep && new_frame) begin
				last_frame_q     <= frame_q;
				last_valid_q     <= 1'b1;
				cursor_q[slot_q] <= '0;
				live_q           <= live_q & ~slot_mask;
			end
			if (cmd.advance) begin
				cursor_q[slot_q] <= cur + CNT_W'(1);
			end
			if (cmd.hit) begin
				live_q[ent] <= 1'b1;
			end
			if (cmd.append) begin
				live_q[ent_new]  <= 1'b1;
				cursor_q[slot_q] <= cnt;
				count_q[slot_q]  <= cnt + CNT_W'(1);
			end
		end
	end

	// payload: request capture, chunk stores, result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q <= frame_number;
			slot_q  <= slot_index;
			req_q   <= request_bytes;
		end
		if (cmd.prep) begin
			aligned_q <= aligned_d;
		end
		if (cmd.hit) begin
			offset_q[ent]   <= off_sum[SIZE_BITS-1:0];
			chunk_index_q   <= cur[CHUNK_W-1:0];
			byte_offset_q   <= off_eff;
			new_chunk_q     <= 1'b0;
			new_bytes_q     <= '0;
			full_res_q      <= 1'b0;
		end
		if (cmd.append) begin
			offset_q[ent_new] <= aligned_q;
			cap_q[ent_new]    <= new_cap;
			chunk_index_q     <= cnt[CHUNK_W-1:0];
			byte_offset_q     <= '0;
			new_chunk_q       <= 1'b1;
			new_bytes_q       <= new_cap;
			full_res_q        <= 1'b0;
		end
		if (cmd.full) begin
			chunk_index_q <= '0;
			byte_offset_q <= '0;
			new_chunk_q   <= 1'b0;
			new_bytes_q   <= '0;
			full_res_q    <= 1'b1;
		end
	end

	assign done            = done_q;
	assign chunk_index     = chunk_index_q;
	assign byte_offset     = byte_offset_q;
	assign new_chunk       = new_chunk_q;
	assign new_chunk_bytes = new_bytes_q;
	assign full_res        = full_res_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= CNT_W'(MAX_CHUNKS) && count_q[1] <= CNT_W'(MAX_CHUNKS))
		else $error("chunk count beyond slot capacity");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q[0] <= count_q[0] && cursor_q[1] <= count_q[1])
		else $error("cursor past chunk count");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(new_chunk_q && full_res_q))
		else $error("result flags both append and failure");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q[$past(slot_q)] == $past(cnt) + CNT_W'(1))
		else $error("append did not grow the slot");

endmodule : pfcba_dp
`default_nettype wire

// ===== rtl/per_frame_chunked_bump_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_frame_chunked_bump_allocator
// Bump allocator over up to MAX_CHUNKS chunks per frame-in-flight slot, with
// per-frame recycling of offsets and chunk append on overflow.
// ----------------------------------------------------------------------------
// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------------------
// request   | start / busy        | frame_number, slot_index, request_bytes
// result    | done (one cycle)    | chunk_index, byte_offset, new_chunk,
//           |                     | new_chunk_bytes, full_res
// config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// From acceptance, a request passes the PREP state and then the SCAN state, which
// steps over k chunks from the slot's cursor (0..8) before the done strobe.
// PREP does frame recycle and size rounding; the scan then tests one
// chunk a cycle through the single offset/capacity lookup at the cursor.
// busy is low again in the cycle the result is shown, so the next request
// may be taken then. Reset clears cursors, counts and frame tracking at once;
// the result receiver cannot stall.
// ----------------------------------------------------------------------------
module per_frame_chunked_bump_allocator
	import pfcba_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// request
	input  wire                   start,
	output logic                  busy,
	input  wire  [FRAME_W-1:0]    frame_number,
	input  wire  [SLOT_W-1:0]     slot_index,
	input  wire  [REQ_W-1:0]      request_bytes,
	// result
	output logic                  done,
	output logic [CHUNK_W-1:0]    chunk_index,
	output logic [SIZE_BITS-1:0]  byte_offset,
	output logic                  new_chunk,
	output logic [SIZE_BITS-1:0]  new_chunk_bytes,
	output logic                  full_res,
	// configuration
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	pfcba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfcba_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.frame_number    (frame_number),
		.slot_index      (slot_index),
		.request_bytes   (request_bytes),
		.cmd             (cmd),
		.sts             (sts),
		.done            (done),
		.chunk_index     (chunk_index),
		.byte_offset     (byte_offset),
		.new_chunk       (new_chunk),
		.new_chunk_bytes (new_chunk_bytes),
		.full_res        (full_res)
	);

endmodule : per_frame_chunked_bump_allocator
`default_nettype wire
